// ===== rtl/tmsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tmsa_pkg
// Shared types and constants of the trimmed-mean sample averager.
// ----------------------------------------------------------------------------
package tmsa_pkg;

  // Width of the samples-per-batch count and of the configuration data.
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // One minimum and one maximum leave the batch when it holds more than this.
  localparam logic [COUNT_W-1:0] TRIM_CUT = 8'd2;

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST  = 8'd20;
  localparam logic               DOUBLE_RESULT_RST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT  = 1'b0,
    REG_DOUBLE_RESULT = 1'b1
  } cfg_reg_e;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/tmsa_div.sv =====
// ----------------------------------------------------------------------------
// tmsa_div
// Restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmsa_div
  import tmsa_pkg::*;
#(
  parameter int unsigned NUM_W = 20,
  parameter int unsigned DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic [NUM_W-1:0] quotient_o,
  output div_stat_t        stat_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] div_q, div_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Bring down the next dividend bit and try the subtract.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      rem_d  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d  = {quo_q[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

// ===== rtl/trimmed_mean_sample_averager.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_sample_averager
// Batch averager of ADC samples; drops one minimum and one maximum when a batch holds more than two.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload (low bit first)      handshake
//   s_axis    in         tdata: sample_mv             tvalid / tready
//   m_axis    out        tdata: average_mv            tvalid / tready
//   cfg       in         idx 0 sample_count, 1 double  cfg_we_i, no wait
//
// Sequence: a sample that does not close its batch is simply accumulated. The
//   sample that closes a batch is accepted, then the operands are loaded,
//   the bit-serial divider takes SAMPLE_BITS + 8 steps, its done flag is
//   seen, and the result is posted to the output register.
// Reset: sample_count = 20, double_result = 1, batch cleared, no result held.
// Stalls: the result sits in an output register; the next batch is taken
//   while it waits. A second result waits in its post cycle for that register
//   to drain, and s_axis_tready_o stays low meanwhile.
// ----------------------------------------------------------------------------
module trimmed_mean_sample_averager
  import tmsa_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Sample stream
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata_i,  // [SAMPLE_BITS-1:0] sample_mv
  // Result stream
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [((SAMPLE_BITS+8)/8)*8-1:0]       m_axis_tdata_o,  // [SAMPLE_BITS:0] average_mv
  // Configuration writes
  input  logic                                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                  cfg_data_i
);

  localparam int unsigned SUM_W    = SAMPLE_BITS + COUNT_W;
  localparam int unsigned OUT_W    = SAMPLE_BITS + 1;
  localparam int unsigned OUT_TD_W = ((SAMPLE_BITS + 8) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_POST
  } state_e;

  state_e                 state_q, state_d;
  logic [COUNT_W-1:0]     cnt_cfg_q, cnt_cfg_d;
  logic                   dbl_q, dbl_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] min_q, min_d;
  logic [SAMPLE_BITS-1:0] max_q, max_d;
  logic [COUNT_W-1:0]     seen_q, seen_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_W-1:0]       out_data_q, out_data_d;

  logic [SAMPLE_BITS-1:0] sample;
  logic [COUNT_W-1:0]     seen_inc;
  logic [COUNT_W-1:0]     target;
  logic                   in_acc;
  logic                   closing;
  logic                   trim;
  logic                   div_start;
  logic [SUM_W-1:0]       dividend;
  logic [COUNT_W-1:0]     divisor;
  logic [SUM_W-1:0]       quotient;
  logic [SAMPLE_BITS-1:0] avg;
  div_stat_t              div_stat;

  assign sample   = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign seen_inc = seen_q + 1'b1;
  // A count of zero behaves as one: every sample closes its own batch.
  assign target   = (cnt_cfg_q == '0) ? COUNT_W'(1) : cnt_cfg_q;
  // Close as soon as the count reaches or passes the target.
  assign closing  = (seen_inc >= target);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  // Trim one minimum and one maximum only when the batch holds more than two samples.
  assign trim      = (seen_q > TRIM_CUT);
  assign div_start = (state_q == ST_LOAD);
  assign dividend  = trim ? (sum_q - SUM_W'(min_q) - SUM_W'(max_q)) : sum_q;
  assign divisor   = trim ? (seen_q - TRIM_CUT) : seen_q;

  tmsa_div #(
    .NUM_W (SUM_W),
    .DEN_W (COUNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // The average never exceeds the largest sample, so the low bits hold it.
  assign avg = quotient[SAMPLE_BITS-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_cfg_d   = cnt_cfg_q;
    dbl_d       = dbl_q;
    sum_d       = sum_q;
    min_d       = min_q;
    max_d       = max_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SAMPLE_COUNT:  cnt_cfg_d = cfg_data_i;
        REG_DOUBLE_RESULT: dbl_d     = cfg_data_i[0];
        default: ;
      endcase
    end

    // Drop the held result once the sink takes it.
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sum_d  = sum_q + SUM_W'(sample);
          min_d  = (sample < min_q) ? sample : min_q;
          max_d  = (sample > max_q) ? sample : max_q;
          seen_d = seen_inc;
          if (closing) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        // Divider latches its operands here; clear the batch for the next run.
        sum_d   = '0;
        min_d   = '1;
        max_d   = '0;
        seen_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = dbl_q ? {avg, 1'b0} : {1'b0, avg};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_cfg_q   <= SAMPLE_COUNT_RST;
      dbl_q       <= DOUBLE_RESULT_RST;
      sum_q       <= '0;
      min_q       <= '1;
      max_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_cfg_q   <= cnt_cfg_d;
      dbl_q       <= dbl_d;
      sum_q       <= sum_d;
      min_q       <= min_d;
      max_q       <= max_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TD_W'(out_data_q);

  // A closing sample always hands the batch to the divider next.
  a_close_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && closing) |=> (state_q == ST_LOAD))
    else $error("closing sample did not start a division");

  // The batch is empty once its operands have gone to the divider.
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> (seen_q == '0 && sum_q == '0))
    else $error("batch not cleared after load");

  // The divider only finishes while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  // Divider runs only between load and post.
  a_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == ST_DIV))
    else $error("divider busy outside the divide phase");

  // A non-empty batch has its minimum at or below its maximum.
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q != '0) |-> (min_q <= max_q))
    else $error("running minimum above running maximum");

endmodule
